@@ src/kscl_pkg.sv @@
`default_nettype none

package kscl_pkg;

    // Default keypad geometry and code length
    localparam int DEF_KEY_ROWS    = 4;
    localparam int DEF_KEY_COLS    = 4;
    localparam int DEF_CODE_LENGTH = 4;

    // Register reset values
    localparam logic [15:0] CODE_KEYS_RST = 16'hF4A2;
    localparam logic [15:0] SETTLE_RST    = 16'd1000;
    localparam logic [15:0] DEBOUNCE_RST  = 16'd20000;

    // LED colors
    localparam logic [1:0] LED_YELLOW = 2'd0;
    localparam logic [1:0] LED_BLUE   = 2'd1;
    localparam logic [1:0] LED_RED    = 2'd2;

    // Code check events
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_CORRECT = 2'd1;
    localparam logic [1:0] EV_WRONG   = 2'd2;

    // Released key handed to the lock
    typedef struct packed {
        logic       fire;
        logic [3:0] index;
    } key_evt_t;

    // Lock decision for the current request
    typedef struct packed {
        logic       restart;
        logic       led_valid;
        logic [1:0] led_color;
        logic [1:0] code_event;
        logic       is_unlocked;
        logic       unlocked_next;
    } lock_resp_t;

endpackage

`default_nettype wire

@@ src/keypad_scan_code_lock.sv @@
`default_nettype none

// Matrix keypad scanner with code lock. Each request carries one sample of the
// active-low row lines and yields exactly one result: the column drive that
// applied to that sample, any released key, LED command, code check event and
// the lock state. A request passes an input register and then a result
// register, and one request is taken every cycle while results are being
// drained. Settle and debounce delays are counted in requests, not clock
// cycles. Configuration writes are taken at any time (cfg_ready is always
// high) and must be made while the block is idle.
module keypad_scan_code_lock #(
    parameter int KEY_ROWS    = kscl_pkg::DEF_KEY_ROWS,
    parameter int KEY_COLS    = kscl_pkg::DEF_KEY_COLS,
    parameter int CODE_LENGTH = kscl_pkg::DEF_CODE_LENGTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  row_lines,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       column_drive,
    output logic             key_valid,
    output logic [3:0]       key_index,
    output logic             led_valid,
    output logic [1:0]       led_color,
    output logic [1:0]       code_event,
    output logic             unlocked
);
    import kscl_pkg::*;

    localparam logic [1:0] CFG_CODE_KEYS = 2'd0;
    localparam logic [1:0] CFG_SETTLE    = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE  = 2'd2;

    localparam logic [1:0] PH_SETTLE   = 2'd0;
    localparam logic [1:0] PH_SAMPLE   = 2'd1;
    localparam logic [1:0] PH_DEBOUNCE = 2'd2;
    localparam logic [1:0] PH_RELEASE  = 2'd3;

    localparam logic [2:0] ROWS3 = 3'(KEY_ROWS);
    localparam logic [2:0] COLS3 = 3'(KEY_COLS);

    logic [15:0] code_keys_reg, settle_reg, debounce_reg;

    logic        in_valid_reg;
    logic [3:0]  in_rows_reg;
    logic        out_free, advance;

    logic [1:0]  scan_col_reg, scan_col_next;
    logic [1:0]  scan_row_reg, scan_row_next;
    logic [1:0]  scan_phase_reg, scan_phase_next;
    logic [15:0] wait_reg, wait_next;

    logic        row_low;
    logic [3:0]  col_drive;
    logic [3:0]  key_k;
    logic        key_fire;
    logic        yellow;
    key_evt_t    key_evt;
    lock_resp_t  lock_resp;

    logic        out_valid_reg;
    logic [3:0]  col_drive_reg, key_index_reg;
    logic        key_valid_reg, led_valid_reg, unlocked_reg;
    logic [1:0]  led_color_reg, code_event_reg;

    // Write configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_keys_reg <= CODE_KEYS_RST;
            settle_reg    <= SETTLE_RST;
            debounce_reg  <= DEBOUNCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CODE_KEYS: code_keys_reg <= cfg_data;
                CFG_SETTLE:    settle_reg    <= cfg_data;
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Advance a request from the input register into the result register
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_rows_reg <= row_lines;
    end

    // Sample the selected row and build the key index
    assign row_low   = !in_rows_reg[scan_row_reg];
    assign col_drive = ~(4'b0001 << scan_col_reg);
    assign key_k     = 4'({2'b00, scan_row_reg} * 4'(KEY_COLS)) + {2'b00, scan_col_reg};
    assign key_fire  = advance && (scan_phase_reg == PH_RELEASE) && !row_low;

    assign key_evt.fire  = key_fire;
    assign key_evt.index = key_k;

    kscl_lock #(
        .KEY_ROWS    (KEY_ROWS),
        .KEY_COLS    (KEY_COLS),
        .CODE_LENGTH (CODE_LENGTH)
    ) u_lock (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_evt   (key_evt),
        .code_keys (code_keys_reg),
        .resp      (lock_resp)
    );

    // Step the scan sequencer
    always_comb
    begin
        scan_col_next   = scan_col_reg;
        scan_row_next   = scan_row_reg;
        scan_phase_next = scan_phase_reg;
        wait_next       = wait_reg;
        yellow          = 1'b0;
        if (advance)
        begin
            unique case (scan_phase_reg)
                PH_SETTLE:
                begin
                    if (wait_reg < settle_reg)
                    begin
                        wait_next = wait_reg + 16'd1;
                    end
                    else
                    begin
                        scan_row_next   = 2'd0;
                        scan_phase_next = PH_SAMPLE;
                    end
                end
                PH_SAMPLE:
                begin
                    if (row_low)
                    begin
                        scan_phase_next = PH_DEBOUNCE;
                        wait_next       = 16'd0;
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (wait_reg < debounce_reg)
                    begin
                        wait_next = wait_reg + 16'd1;
                    end
                    else if (row_low)
                    begin
                        scan_phase_next = PH_RELEASE;
                        wait_next       = 16'd0;
                        yellow          = !lock_resp.is_unlocked;
                    end
                end
                PH_RELEASE:
                begin
                    if (!row_low && lock_resp.restart)
                    begin
                        scan_col_next   = 2'd0;
                        scan_row_next   = 2'd0;
                        scan_phase_next = PH_SETTLE;
                        wait_next       = 16'd0;
                    end
                end
                default: ;
            endcase

            // Move to the next row, or the next column after the last row
            if ((scan_phase_reg == PH_SAMPLE && !row_low)
                || (scan_phase_reg == PH_DEBOUNCE && wait_reg >= debounce_reg && !row_low)
                || (scan_phase_reg == PH_RELEASE && !row_low && !lock_resp.restart))
            begin
                if ({1'b0, scan_row_reg} + 3'd1 < ROWS3)
                begin
                    scan_row_next   = scan_row_reg + 2'd1;
                    scan_phase_next = PH_SAMPLE;
                end
                else
                begin
                    scan_row_next   = 2'd0;
                    scan_col_next   = ({1'b0, scan_col_reg} + 3'd1 < COLS3)
                                      ? scan_col_reg + 2'd1 : 2'd0;
                    scan_phase_next = PH_SETTLE;
                    wait_next       = 16'd0;
                end
            end
        end
    end

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_col_reg   <= 2'd0;
            scan_row_reg   <= 2'd0;
            scan_phase_reg <= PH_SETTLE;
            wait_reg       <= 16'd0;
        end
        else
        begin
            scan_col_reg   <= scan_col_next;
            scan_row_reg   <= scan_row_next;
            scan_phase_reg <= scan_phase_next;
            wait_reg       <= wait_next;
        end
    end

    // Capture the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col_drive_reg  <= col_drive;
            key_valid_reg  <= key_fire;
            key_index_reg  <= key_fire ? key_k : 4'd0;
            led_valid_reg  <= yellow || lock_resp.led_valid;
            led_color_reg  <= yellow ? LED_YELLOW : lock_resp.led_color;
            code_event_reg <= lock_resp.code_event;
            unlocked_reg   <= lock_resp.unlocked_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = col_drive_reg;
    assign key_valid    = key_valid_reg;
    assign key_index    = key_index_reg;
    assign led_valid    = led_valid_reg;
    assign led_color    = led_color_reg;
    assign code_event   = code_event_reg;
    assign unlocked     = unlocked_reg;

`ifndef ASSERT_OFF
    // A code event only comes with a reported key
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && code_event != EV_NONE) |-> key_valid)
        else $error("code event without key");

    // Exactly one column is driven low
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(~column_drive) == 1))
        else $error("column drive not one-cold");

    // Settling always starts from the first row
    assert property (@(posedge clk) disable iff (!rst_n)
        (scan_phase_reg == PH_SETTLE) |-> (scan_row_reg == 2'd0))
        else $error("settle phase with nonzero row");

    // A correct code leaves the lock open
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && code_event == EV_CORRECT) |-> unlocked)
        else $error("correct code without unlock");
`endif

endmodule

`default_nettype wire

@@ src/kscl_lock.sv @@
`default_nettype none

module kscl_lock #(
    parameter int KEY_ROWS    = kscl_pkg::DEF_KEY_ROWS,
    parameter int KEY_COLS    = kscl_pkg::DEF_KEY_COLS,
    parameter int CODE_LENGTH = kscl_pkg::DEF_CODE_LENGTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kscl_pkg::key_evt_t   key_evt,
    input  wire logic [15:0]          code_keys,
    output kscl_pkg::lock_resp_t      resp
);
    import kscl_pkg::*;

    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(CODE_LENGTH - 1);
    localparam logic [3:0]       RELOCK_KEY = 4'(KEY_ROWS * KEY_COLS - 1);

    logic [3:0]       entered_reg [CODE_LENGTH];
    logic [IDX_W-1:0] count_reg, count_next;
    logic             unlocked_reg, unlocked_next;
    logic             match;

    // Compare gathered digits, the newest key standing in for the last one
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (i == CODE_LENGTH - 1)
            begin
                if (key_evt.index != code_keys[4*i +: 4])
                    match = 1'b0;
            end
            else if (entered_reg[i] != code_keys[4*i +: 4])
            begin
                match = 1'b0;
            end
        end
    end

    // Decide lock reaction to a released key
    always_comb
    begin
        count_next         = count_reg;
        unlocked_next      = unlocked_reg;
        resp.restart       = 1'b0;
        resp.led_valid     = 1'b0;
        resp.led_color     = LED_YELLOW;
        resp.code_event    = EV_NONE;
        resp.is_unlocked   = unlocked_reg;
        if (key_evt.fire)
        begin
            if (unlocked_reg)
            begin
                if (key_evt.index == RELOCK_KEY)
                begin
                    unlocked_next  = 1'b0;
                    resp.restart   = 1'b1;
                    resp.led_valid = 1'b1;
                    resp.led_color = LED_RED;
                end
            end
            else
            begin
                resp.restart = 1'b1;
                if (count_reg == LAST_IDX)
                begin
                    count_next     = '0;
                    resp.led_valid = 1'b1;
                    if (match)
                    begin
                        unlocked_next   = 1'b1;
                        resp.led_color  = LED_BLUE;
                        resp.code_event = EV_CORRECT;
                    end
                    else
                    begin
                        resp.led_color  = LED_RED;
                        resp.code_event = EV_WRONG;
                    end
                end
                else
                begin
                    count_next = count_reg + IDX_W'(1);
                end
            end
        end
        resp.unlocked_next = unlocked_next;
    end

    // Hold lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            unlocked_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            unlocked_reg <= unlocked_next;
        end
    end

    // Store entered digits
    always_ff @(posedge clk)
    begin
        if (key_evt.fire && !unlocked_reg)
            entered_reg[count_reg] <= key_evt.index;
    end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb;

    import kscl_pkg::*;

    // Register addresses on the configuration channel
    localparam logic [1:0] REG_CODE     = 2'd0;
    localparam logic [1:0] REG_SETTLE   = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE = 2'd2;
    localparam logic [1:0] REG_SPARE    = 2'd3;

    // Key that locks the door again while it is open
    localparam logic [3:0] RELOCK_KEY = 4'hF;

    typedef enum logic [1:0] {
        SCAN_SETTLE,
        SCAN_SAMPLE,
        SCAN_DEBOUNCE,
        SCAN_RELEASE
    } scan_phase_t;

    typedef struct packed {
        logic [3:0] column_drive;
        logic       key_valid;
        logic [3:0] key_index;
        logic       led_valid;
        logic [1:0] led_color;
        logic [1:0] code_event;
        logic       unlocked;
    } scan_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  row_lines;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  column_drive;
    logic        key_valid;
    logic [3:0]  key_index;
    logic        led_valid;
    logic [1:0]  led_color;
    logic [1:0]  code_event;
    logic        unlocked;

    // Scanner and lock state as the bench expects it
    scan_phase_t cur_phase;
    logic [1:0]  cur_col;
    logic [1:0]  cur_row;
    logic [15:0] tick_count;
    logic [3:0]  digits [4];
    logic [2:0]  digit_count;
    logic        lock_open;

    // Register contents as the bench expects them
    logic [15:0] secret_code;
    logic [15:0] settle_len;
    logic [15:0] debounce_len;

    scan_result_t expected_results [$];
    int           mismatches = 0;
    int           rows_sent  = 0;
    bit           idle_on    = 1'b1;

    keypad_scan_code_lock uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row_lines    (row_lines),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_drive (column_drive),
        .key_valid    (key_valid),
        .key_index    (key_index),
        .led_valid    (led_valid),
        .led_color    (led_color),
        .code_event   (code_event),
        .unlocked     (unlocked)
    );

    always #1 clk = ~clk;

    // Pick a gap before the next transfer on either side
    function automatic int draw_gap();
        if (!idle_on)
        begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    task automatic clear_lock_model();
        secret_code  = CODE_KEYS_RST;
        settle_len   = SETTLE_RST;
        debounce_len = DEBOUNCE_RST;
        cur_phase    = SCAN_SETTLE;
        cur_col      = 2'd0;
        cur_row      = 2'd0;
        tick_count   = 16'd0;
        digit_count  = 3'd0;
        lock_open    = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            digits[i] = 4'd0;
        end
    endtask

    task automatic restart_scan();
        cur_col    = 2'd0;
        cur_row    = 2'd0;
        cur_phase  = SCAN_SETTLE;
        tick_count = 16'd0;
    endtask

    // Advance to the next row, or to the next column after the last row
    task automatic advance_row();
        if (cur_row != 2'd3)
        begin
            cur_row   = cur_row + 2'd1;
            cur_phase = SCAN_SAMPLE;
        end
        else
        begin
            cur_row    = 2'd0;
            cur_col    = cur_col + 2'd1;
            cur_phase  = SCAN_SETTLE;
            tick_count = 16'd0;
        end
    endtask

    // Work out the result of one row sample and step the scanner and lock
    task automatic scan_tick(input logic [3:0] rows, output scan_result_t res);
        logic       row_low;
        logic [3:0] hit;
        logic       code_ok;
        res = '0;
        row_low = ~rows[cur_row];
        hit = {cur_row, cur_col};
        res.column_drive = ~(4'b0001 << cur_col);
        unique case (cur_phase)
            SCAN_SETTLE:
            begin
                if (tick_count < settle_len)
                begin
                    tick_count = tick_count + 16'd1;
                end
                else
                begin
                    cur_row   = 2'd0;
                    cur_phase = SCAN_SAMPLE;
                end
            end
            SCAN_SAMPLE:
            begin
                if (row_low)
                begin
                    cur_phase  = SCAN_DEBOUNCE;
                    tick_count = 16'd0;
                end
                else
                begin
                    advance_row();
                end
            end
            SCAN_DEBOUNCE:
            begin
                if (tick_count < debounce_len)
                begin
                    tick_count = tick_count + 16'd1;
                end
                else if (row_low)
                begin
                    cur_phase  = SCAN_RELEASE;
                    tick_count = 16'd0;
                    if (!lock_open)
                    begin
                        res.led_valid = 1'b1;
                        res.led_color = LED_YELLOW;
                    end
                end
                else
                begin
                    advance_row();
                end
            end
            default:
            begin
                if (!row_low)
                begin
                    res.key_valid = 1'b1;
                    res.key_index = hit;
                    if (lock_open)
                    begin
                        if (hit == RELOCK_KEY)
                        begin
                            lock_open     = 1'b0;
                            res.led_valid = 1'b1;
                            res.led_color = LED_RED;
                            restart_scan();
                        end
                        else
                        begin
                            advance_row();
                        end
                    end
                    else
                    begin
                        // store the digit, compare once the code is complete
                        digits[digit_count[1:0]] = hit;
                        digit_count = digit_count + 3'd1;
                        if (digit_count >= 3'd4)
                        begin
                            code_ok = 1'b1;
                            for (int i = 0; i < 4; i++)
                            begin
                                if (digits[i] != secret_code[4 * i +: 4])
                                begin
                                    code_ok = 1'b0;
                                end
                                digits[i] = 4'd0;
                            end
                            digit_count   = 3'd0;
                            res.led_valid = 1'b1;
                            if (code_ok)
                            begin
                                lock_open      = 1'b1;
                                res.led_color  = LED_BLUE;
                                res.code_event = EV_CORRECT;
                            end
                            else
                            begin
                                res.led_color  = LED_RED;
                                res.code_event = EV_WRONG;
                            end
                        end
                        restart_scan();
                    end
                end
            end
        endcase
        res.unlocked = lock_open;
    endtask

    // Send one row sample and queue the result it must produce
    task automatic send_rows(input logic [3:0] rows, output scan_result_t res);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        row_lines <= rows;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        scan_tick(rows, res);
        expected_results.push_back(res);
        rows_sent++;
    endtask

    // Drop the request line and let every outstanding result drain
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        unique case (idx)
            REG_CODE:     secret_code  = data;
            REG_SETTLE:   settle_len   = data;
            REG_DEBOUNCE: debounce_len = data;
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] code, input logic [15:0] settle,
                             input logic [15:0] debounce);
        wait_drained();
        write_reg(REG_CODE, code);
        write_reg(REG_SETTLE, settle);
        write_reg(REG_DEBOUNCE, debounce);
    endtask

    // Hold a key down until the scanner reports a release, with contact bounce
    task automatic press_key(input logic [3:0] k, input int hold);
        scan_result_t res;
        logic [3:0]   rows;
        int           held;
        held = 0;
        res  = '0;
        while (!res.key_valid)
        begin
            rows = 4'hF;
            if (cur_col == k[1:0])
            begin
                rows[k[3:2]] = 1'b0;
            end
            if (cur_phase == SCAN_RELEASE)
            begin
                if (held < hold)
                begin
                    held++;
                end
                else
                begin
                    rows = 4'hF;
                end
            end
            else if (cur_phase == SCAN_DEBOUNCE && $urandom_range(0, 7) == 0)
            begin
                rows = 4'hF;
            end
            send_rows(rows, res);
        end
    endtask

    // Enter four digits, the right code or a corrupted one
    task automatic enter_code(input bit correct);
        logic [15:0] seq;
        int          slot;
        while (!lock_open && digit_count != 3'd0)
        begin
            press_key(4'($urandom_range(0, 15)), 0);
        end
        seq = secret_code;
        if (!correct)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                seq = 16'($urandom_range(0, 65535));
            end
            else
            begin
                slot = $urandom_range(0, 3);
                seq[4 * slot +: 4] = seq[4 * slot +: 4] ^ 4'($urandom_range(1, 15));
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            press_key(seq[4 * i +: 4], $urandom_range(0, 3));
        end
    endtask

    task automatic send_noise(input int count);
        scan_result_t res;
        repeat (count)
        begin
            send_rows(4'($urandom_range(0, 15)), res);
        end
    endtask

    // Power-up register values: the long settle delay keeps the column drive still
    task automatic test_reset_values();
        send_noise(6);
    endtask

    // Right and wrong codes, ignored keys, relock, zero delays, spare register
    task automatic test_code_entry();
        scan_result_t res;
        configure(16'hFFFF, 16'd0, 16'd0);
        write_reg(REG_SPARE, 16'hFFFF);
        send_rows(4'h0, res);
        send_rows(4'h0, res);
        send_rows(4'hF, res);
        enter_code(1'b1);
        press_key(4'd5, 1);
        press_key(RELOCK_KEY, 0);
        configure(16'h0000, 16'd1, 16'd2);
        write_reg(REG_SPARE, 16'h0000);
        enter_code(1'b0);
        enter_code(1'b1);
        press_key(4'd0, 2);
        press_key(RELOCK_KEY, 3);
    endtask

    // Largest settle and debounce while the counters run, no idling on either side
    task automatic test_long_waits();
        idle_on = 1'b0;
        configure(16'($urandom_range(0, 65535)), 16'hFFFF, 16'hFFFF);
        send_noise(20);
        configure(secret_code, 16'd0, 16'hFFFF);
        send_noise(30);
        configure(CODE_KEYS_RST, 16'd2, 16'd3);
        idle_on = 1'b1;
    endtask

    // Mostly well-formed code sessions with random content, some line noise
    task automatic test_random_sessions();
        int pick;
        while (rows_sent < 950)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
            begin
                configure(16'($urandom_range(0, 65535)),
                          ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, 4)),
                          16'($urandom_range(0, 6)));
                if ($urandom_range(0, 3) == 0)
                begin
                    write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
                end
            end
            if (lock_open)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    press_key(($urandom_range(0, 2) == 0) ? RELOCK_KEY
                                                          : 4'($urandom_range(0, 15)),
                              $urandom_range(0, 3));
                end
            end
            else
            begin
                pick = $urandom_range(0, 8);
                if (pick < 6)
                begin
                    enter_code(pick < 3);
                end
                else if (pick < 8)
                begin
                    send_noise($urandom_range(1, 20));
                end
                else
                begin
                    press_key(4'($urandom_range(0, 15)), $urandom_range(0, 4));
                end
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each delivered result with the oldest queued one
    initial
    begin : result_checker
        int           stall;
        scan_result_t want;
        out_ready = 1'b0;
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $error("result delivered with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("column_drive", want.column_drive, column_drive);
                check_field("key_valid", want.key_valid, key_valid);
                check_field("key_index", want.key_index, key_index);
                check_field("led_valid", want.led_valid, led_valid);
                check_field("led_color", want.led_color, led_color);
                check_field("code_event", want.code_event, code_event);
                check_field("unlocked", want.unlocked, unlocked);
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CODE;
        cfg_data  = 16'd0;
        in_valid  = 1'b0;
        row_lines = 4'hF;
        clear_lock_model();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_code_entry();
        test_long_waits();
        test_random_sessions();
        wait_drained();
        if (mismatches == 0)
        begin
            $display("keypad_scan_code_lock regression: pass");
        end
        else
        begin
            $display("keypad_scan_code_lock regression: fail");
        end
        $finish;
    end

    // Hard stop if the handshakes hang
    initial
    begin
        #2000000;
        $display("keypad_scan_code_lock regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
